/* sv/rprq_pkg.sv */
package rprq_pkg;

  localparam int unsigned MaxDepthDefault  = 256;
  localparam int unsigned DataWidthDefault = 64;
  localparam int unsigned FuncW            = 3;
  localparam int unsigned SlotW            = 8;
  localparam int unsigned CapW             = 4;
  localparam logic [CapW-1:0] CapReset     = 4'd8;

  typedef enum logic [FuncW-1:0] {
    FUNC_RESERVE = 3'd0,
    FUNC_PUBLISH = 3'd1,
    FUNC_PEEK    = 3'd2,
    FUNC_POP     = 3'd3,
    FUNC_SKIP    = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_NOT_READY = 3'd3,
    STAT_DISABLED  = 3'd4,
    STAT_BAD_SLOT  = 3'd5,
    STAT_NO_STALL  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHK,
    S_EXEC,
    S_OUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic read2;
    logic exec;
    logic cfg_write;
  } dp_cmd_t;

endpackage

/* sv/rprq_ctrl.sv */
module rprq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  output rprq_pkg::dp_cmd_t  cmd_o
);

  rprq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rprq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cfg_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      rprq_pkg::S_IDLE: begin
        cfg_ready_o     = 1'b1;
        in_ready_o      = !cfg_valid_i;
        cmd_o.cfg_write = cfg_valid_i;
        if (in_valid_i && !cfg_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = rprq_pkg::S_CHK;
        end
      end
      rprq_pkg::S_CHK: begin
        cmd_o.read2 = 1'b1;
        state_d     = rprq_pkg::S_EXEC;
      end
      rprq_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = rprq_pkg::S_OUT;
      end
      rprq_pkg::S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = rprq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rprq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* sv/rprq_dp.sv */
module rprq_dp #(
  parameter int unsigned MAX_DEPTH  = rprq_pkg::MaxDepthDefault,
  parameter int unsigned DATA_WIDTH = rprq_pkg::DataWidthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rprq_pkg::dp_cmd_t              cmd_i,
  input  logic [rprq_pkg::CapW-1:0]      cfg_data_i,
  input  logic [rprq_pkg::FuncW-1:0]     func_i,
  input  logic [rprq_pkg::SlotW-1:0]     slot_index_i,
  input  logic [DATA_WIDTH-1:0]          payload_i,
  output logic [2:0]                     status_o,
  output logic [rprq_pkg::SlotW-1:0]     result_slot_o,
  output logic [DATA_WIDTH-1:0]          result_data_o,
  output logic                           head_stalled_o
);

  localparam int unsigned IdxW = $clog2(MAX_DEPTH);

  logic [rprq_pkg::CapW-1:0]   cap_q;
  logic [IdxW-1:0]             head_q, head_d, tail_q, tail_d;
  logic [rprq_pkg::FuncW-1:0]  func_q;
  logic [rprq_pkg::SlotW-1:0]  slot_q;
  logic [DATA_WIDTH-1:0]       pay_q;

  logic                        ready_mem [MAX_DEPTH];
  logic [DATA_WIDTH-1:0]       pay_mem   [MAX_DEPTH];
  logic                        rd_q, rh_q;
  logic [DATA_WIDTH-1:0]       pd_q;

  rprq_pkg::status_e           status_q, status_d;
  logic [rprq_pkg::SlotW-1:0]  rslot_q, rslot_d;
  logic [DATA_WIDTH-1:0]       rdata_q, rdata_d;
  logic                        stall_q, stall_d;

  logic [4:0]                  cap_ext, lg;
  logic [IdxW-1:0]             mask, h1, t1, slot_ix, raddr;
  logic                        h_eq_t, slot_big, in_span, pub_bad;
  logic                        rwe, rwbit, pwe;
  logic [IdxW-1:0]             rwaddr;

  assign cap_ext  = {1'b0, cap_q};
  assign lg       = (cap_ext > 5'(IdxW)) ? 5'(IdxW) : cap_ext;
  assign mask     = IdxW'((32'd1 << lg) - 32'd1);
  assign h1       = (head_q + IdxW'(1)) & mask;
  assign t1       = (tail_q + IdxW'(1)) & mask;
  assign h_eq_t   = (head_q == tail_q);
  assign slot_ix  = IdxW'(slot_q);
  assign slot_big = (32'(slot_q) > 32'(mask));
  assign in_span  = (((slot_ix - head_q) & mask) < ((tail_q - head_q) & mask));
  assign pub_bad  = slot_big || !in_span || rd_q;

  always_comb begin
    if (cmd_i.accept) begin
      raddr = head_q;
    end else if (rprq_pkg::func_e'(func_q) == rprq_pkg::FUNC_PUBLISH) begin
      raddr = slot_ix;
    end else begin
      raddr = h1;
    end
  end

  always_comb begin
    status_d = rprq_pkg::STAT_OK;
    rslot_d  = rprq_pkg::SlotW'(head_q);
    rdata_d  = '0;
    stall_d  = !h_eq_t && !rh_q;
    head_d   = head_q;
    tail_d   = tail_q;
    rwe      = 1'b0;
    rwaddr   = head_q;
    rwbit    = 1'b0;
    pwe      = 1'b0;
    if (mask == '0) begin
      status_d = rprq_pkg::STAT_DISABLED;
      rslot_d  = '0;
      stall_d  = 1'b0;
    end else begin
      case (rprq_pkg::func_e'(func_q))
        rprq_pkg::FUNC_RESERVE: begin
          rslot_d = rprq_pkg::SlotW'(tail_q);
          if (t1 == head_q) begin
            status_d = rprq_pkg::STAT_FULL;
          end else begin
            rwe     = 1'b1;
            rwaddr  = tail_q;
            tail_d  = t1;
            stall_d = h_eq_t || !rh_q;
          end
        end
        rprq_pkg::FUNC_PUBLISH: begin
          if (pub_bad) begin
            status_d = rprq_pkg::STAT_BAD_SLOT;
          end else begin
            rwe     = 1'b1;
            rwaddr  = slot_ix;
            rwbit   = 1'b1;
            pwe     = 1'b1;
            stall_d = !h_eq_t && !(rh_q || (slot_ix == head_q));
          end
        end
        rprq_pkg::FUNC_PEEK, rprq_pkg::FUNC_POP: begin
          if (h_eq_t) begin
            status_d = rprq_pkg::STAT_EMPTY;
          end else if (!rh_q) begin
            status_d = rprq_pkg::STAT_NOT_READY;
          end else begin
            rdata_d = pd_q;
            if (rprq_pkg::func_e'(func_q) == rprq_pkg::FUNC_POP) begin
              rwe     = 1'b1;
              head_d  = h1;
              stall_d = (h1 != tail_q) && !rd_q;
            end
          end
        end
        rprq_pkg::FUNC_SKIP: begin
          if (!h_eq_t && !rh_q) begin
            rwe     = 1'b1;
            head_d  = h1;
            stall_d = (h1 != tail_q) && !rd_q;
          end else begin
            status_d = rprq_pkg::STAT_NO_STALL;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= rprq_pkg::CapReset;
      head_q <= '0;
      tail_q <= '0;
    end else if (cmd_i.cfg_write) begin
      cap_q  <= cfg_data_i;
      head_q <= '0;
      tail_q <= '0;
    end else if (cmd_i.exec) begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q <= func_i;
      slot_q <= slot_index_i;
      pay_q  <= payload_i;
      pd_q   <= pay_mem[head_q];
    end
    if (cmd_i.accept || cmd_i.read2) begin
      rd_q <= ready_mem[raddr];
    end
    if (cmd_i.read2) begin
      rh_q <= rd_q;
    end
    if (cmd_i.exec && rwe) begin
      ready_mem[rwaddr] <= rwbit;
    end
    if (cmd_i.exec && pwe) begin
      pay_mem[slot_ix] <= pay_q;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      rslot_q  <= rslot_d;
      rdata_q  <= rdata_d;
      stall_q  <= stall_d;
    end
  end

  assign status_o       = status_q;
  assign result_slot_o  = rslot_q;
  assign result_data_o  = rdata_q;
  assign head_stalled_o = stall_q;

endmodule

/* sv/reserve_publish_ring_queue_core.sv */
// Ring queue of reserved slots with per-slot ready flags, serving one item at a time. An item
// is taken in the idle state, goes through the check and execute states, and its result is
// shown in the output state; once the result is taken the queue is idle again. The pace is
// set by the single read port of the ready-flag memory, which is read twice in sequence (at
// the head and at the publish slot or the next head) before the one write of the item. The
// flags need no reset and no clearing pass: after reset or a capacity write the ring is
// empty, and a slot always has its flag cleared when a reserve brings it into use. A capacity
// write is taken only while no item is in progress.
module reserve_publish_ring_queue_core #(
  parameter int unsigned MAX_DEPTH  = rprq_pkg::MaxDepthDefault,
  parameter int unsigned DATA_WIDTH = rprq_pkg::DataWidthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rprq_pkg::CapW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rprq_pkg::FuncW-1:0]  func_i,
  input  logic [rprq_pkg::SlotW-1:0]  slot_index_i,
  input  logic [DATA_WIDTH-1:0]       payload_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  status_o,
  output logic [rprq_pkg::SlotW-1:0]  result_slot_o,
  output logic [DATA_WIDTH-1:0]       result_data_o,
  output logic                        head_stalled_o
);

  rprq_pkg::dp_cmd_t cmd;

  rprq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd)
  );

  rprq_dp #(
    .MAX_DEPTH  (MAX_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_data_i     (cfg_data_i),
    .func_i         (func_i),
    .slot_index_i   (slot_index_i),
    .payload_i      (payload_i),
    .status_o       (status_o),
    .result_slot_o  (result_slot_o),
    .result_data_o  (result_data_o),
    .head_stalled_o (head_stalled_o)
  );

endmodule

/* sv/rprq_chk.sv */
module rprq_chk #(
  parameter int unsigned DATA_WIDTH = rprq_pkg::DataWidthDefault
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [2:0]                  status_o,
  input logic [rprq_pkg::SlotW-1:0]  result_slot_o,
  input logic [DATA_WIDTH-1:0]       result_data_o,
  input logic                        head_stalled_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(result_slot_o) && $stable(result_data_o) && $stable(head_stalled_o))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("result shown in the cycle after the item was taken");

  a_data_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != 3'(rprq_pkg::STAT_OK) |-> result_data_o == '0)
    else $error("data returned on a failed item");

  a_disabled_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == 3'(rprq_pkg::STAT_DISABLED) |->
    result_slot_o == '0 && !head_stalled_o)
    else $error("disabled ring reported a slot or a stall");

endmodule

bind reserve_publish_ring_queue_core rprq_chk #(
  .DATA_WIDTH (DATA_WIDTH)
) u_rprq_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .result_slot_o  (result_slot_o),
  .result_data_o  (result_data_o),
  .head_stalled_o (head_stalled_o)
);

/* bench/tb_reserve_publish_ring_queue_core.sv */
module tb_reserve_publish_ring_queue_core;

  typedef struct {
    logic [63:0] pay [256];
    bit          rdy [256];
    logic [7:0]  head;
    logic [7:0]  tail;
    logic [3:0]  cap;
  } ring_t;

  typedef struct packed {
    rprq_pkg::status_e status;
    logic [7:0]        slot;
    logic [63:0]       data;
    logic              stalled;
  } result_t;

  typedef struct packed {
    logic        is_cfg;
    logic [3:0]  cap;
    logic [2:0]  func;
    logic [7:0]  slot;
    logic [63:0] payload;
  } pend_t;

  localparam int HoldAt    = 400;
  localparam int HoldLen   = 300;
  localparam int CalmStart = 1500;
  localparam int CalmEnd   = 2300;

  logic        clk         = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid   = 1'b0;
  logic [3:0]  cfg_data    = '0;
  logic        in_valid    = 1'b0;
  logic [2:0]  func        = '0;
  logic [7:0]  slot        = '0;
  logic [63:0] payload     = '0;
  logic        out_ready   = 1'b0;
  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [2:0]  status_o;
  logic [7:0]  result_slot_o;
  logic [63:0] result_data_o;
  logic        head_stalled_o;

  logic        in_took     = 1'b0;
  logic        cfg_took    = 1'b0;
  int          cyc         = 0;
  int          hold_left   = 0;
  int          fails       = 0;
  bit          calm;

  ring_t       ring_now;
  ring_t       ring_plan;
  pend_t       pending_ops[$];
  result_t     awaited_results[$];
  pend_t       next_op;
  result_t     got_ref;

  reserve_publish_ring_queue_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .func_i         (func),
    .slot_index_i   (slot),
    .payload_i      (payload),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .status_o       (status_o),
    .result_slot_o  (result_slot_o),
    .result_data_o  (result_data_o),
    .head_stalled_o (head_stalled_o)
  );

  initial forever #1 clk = ~clk;

  assign calm = (cyc >= CalmStart) && (cyc < CalmEnd);

  function automatic int unsigned ring_mask(input logic [3:0] cap);
    int unsigned lg;
    lg = (cap > 4'd8) ? 8 : int'(cap);
    return (32'd1 << lg) - 1;
  endfunction

  function automatic void ring_setup(inout ring_t r, input logic [3:0] cap);
    int k;
    for (k = 0; k < 256; k++) r.rdy[k] = 1'b0;
    r.head = '0;
    r.tail = '0;
    r.cap  = cap;
  endfunction

  function automatic result_t apply_op(inout ring_t r, input logic [2:0] f,
                                       input logic [7:0] s, input logic [63:0] p);
    int unsigned m, h, t, nx, sl;
    result_t res;
    res.status  = rprq_pkg::STAT_OK;
    res.slot    = '0;
    res.data    = '0;
    res.stalled = 1'b0;
    m = ring_mask(r.cap);
    if (m == 0) begin
      res.status = rprq_pkg::STAT_DISABLED;
      return res;
    end
    h = 32'(r.head) & m;
    t = 32'(r.tail) & m;
    res.slot = h[7:0];
    case (f)
      rprq_pkg::FUNC_RESERVE: begin
        nx = (t + 1) & m;
        res.slot = t[7:0];
        if (nx == h) begin
          res.status = rprq_pkg::STAT_FULL;
        end else begin
          r.rdy[t] = 1'b0;
          r.tail = nx[7:0];
        end
      end
      rprq_pkg::FUNC_PUBLISH: begin
        sl = 32'(s);
        if (sl > m || ((sl - h) & m) >= ((t - h) & m) || r.rdy[sl]) begin
          res.status = rprq_pkg::STAT_BAD_SLOT;
        end else begin
          r.pay[sl] = p;
          r.rdy[sl] = 1'b1;
        end
      end
      rprq_pkg::FUNC_PEEK, rprq_pkg::FUNC_POP: begin
        if (h == t) begin
          res.status = rprq_pkg::STAT_EMPTY;
        end else if (!r.rdy[h]) begin
          res.status = rprq_pkg::STAT_NOT_READY;
        end else begin
          res.data = r.pay[h];
          if (f == rprq_pkg::FUNC_POP) begin
            r.rdy[h] = 1'b0;
            r.head = 8'((h + 1) & m);
          end
        end
      end
      rprq_pkg::FUNC_SKIP: begin
        if (h != t && !r.rdy[h]) begin
          r.head = 8'((h + 1) & m);
        end else begin
          res.status = rprq_pkg::STAT_NO_STALL;
        end
      end
      default: begin
      end
    endcase
    h = 32'(r.head) & m;
    res.stalled = (h != (32'(r.tail) & m)) && !r.rdy[h];
    return res;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_item(input logic [2:0] f, input logic [7:0] s, input logic [63:0] p);
    pend_t e;
    void'(apply_op(ring_plan, f, s, p));
    e.is_cfg  = 1'b0;
    e.cap     = '0;
    e.func    = f;
    e.slot    = s;
    e.payload = p;
    pending_ops.push_back(e);
  endtask

  task automatic push_cfg(input logic [3:0] cap);
    pend_t e;
    ring_setup(ring_plan, cap);
    e.is_cfg  = 1'b1;
    e.cap     = cap;
    e.func    = '0;
    e.slot    = '0;
    e.payload = '0;
    pending_ops.push_back(e);
  endtask

  // Mostly coherent reserve/publish/pop traffic, with most publishes aimed at open slots.
  task automatic add_random(input int n);
    int i;
    int unsigned m, h, t, span, k, r;
    int unsigned open_slots[$];
    logic [2:0] f;
    logic [7:0] s;
    logic [63:0] p;
    for (i = 0; i < n; i++) begin
      open_slots.delete();
      m = ring_mask(ring_plan.cap);
      h = 32'(ring_plan.head) & m;
      t = 32'(ring_plan.tail) & m;
      span = (t - h) & m;
      for (k = 0; k < span; k++) begin
        if (!ring_plan.rdy[(h + k) & m]) open_slots.push_back((h + k) & m);
      end
      s = 8'($urandom);
      p = rnd64();
      if ($urandom_range(0, 15) == 0) p = '0;
      else if ($urandom_range(0, 15) == 0) p = '1;
      r = $urandom_range(0, 99);
      if (r < 30) begin
        f = rprq_pkg::FUNC_RESERVE;
      end else if (r < 55) begin
        f = rprq_pkg::FUNC_PUBLISH;
        if (open_slots.size() > 0) begin
          if ($urandom_range(0, 1) == 0) s = 8'(open_slots[0]);
          else s = 8'(open_slots[$urandom_range(0, open_slots.size() - 1)]);
        end
      end else if (r < 75) begin
        f = rprq_pkg::FUNC_POP;
      end else if (r < 83) begin
        f = rprq_pkg::FUNC_PEEK;
      end else if (r < 88) begin
        f = rprq_pkg::FUNC_SKIP;
      end else if (r < 95) begin
        f = rprq_pkg::FUNC_PUBLISH;
      end else begin
        f = 3'($urandom_range(5, 7));
      end
      push_item(f, s, p);
    end
  endtask

  always @(posedge clk) begin
    in_took  <= in_valid && in_ready_o;
    cfg_took <= cfg_valid && cfg_ready_o;
    cyc      <= cyc + 1;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (awaited_results.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result: status %0d slot %0d", status_o,
                                    result_slot_o);
        end else begin
          got_ref = awaited_results.pop_front();
          if (status_o !== got_ref.status || result_slot_o !== got_ref.slot ||
              result_data_o !== got_ref.data || head_stalled_o !== got_ref.stalled) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch: status %0d/%0d slot %0d/%0d data %h/%h stalled %0b/%0b",
                       got_ref.status, status_o, got_ref.slot, result_slot_o,
                       got_ref.data, result_data_o, got_ref.stalled, head_stalled_o);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready_o) ring_setup(ring_now, cfg_data);
      if (in_valid && in_ready_o) awaited_results.push_back(apply_op(ring_now, func, slot,
                                                                     payload));
    end
  end

  always @(negedge clk) begin
    if (rst_ni) begin
      if (cfg_valid) begin
        if (cfg_took) cfg_valid <= 1'b0;
      end else if (!in_valid || in_took) begin
        if (pending_ops.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_ops[0].is_cfg) begin
          in_valid <= 1'b0;
          if (!in_valid && awaited_results.size() == 0) begin
            next_op = pending_ops.pop_front();
            cfg_data  <= next_op.cap;
            cfg_valid <= 1'b1;
          end
        end else if (!calm && $urandom_range(0, 99) < 9) begin
          in_valid <= 1'b0;
        end else begin
          next_op = pending_ops.pop_front();
          func     <= next_op.func;
          slot     <= next_op.slot;
          payload  <= next_op.payload;
          in_valid <= 1'b1;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (cyc == HoldAt) begin
        hold_left <= HoldLen;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  initial begin
    #200000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    ring_setup(ring_now, rprq_pkg::CapReset);
    ring_setup(ring_plan, rprq_pkg::CapReset);

    push_item(rprq_pkg::FUNC_PEEK, 8'd0, rnd64());
    push_item(rprq_pkg::FUNC_POP, 8'd0, rnd64());
    push_item(rprq_pkg::FUNC_SKIP, 8'd0, rnd64());
    push_item(rprq_pkg::FUNC_PUBLISH, 8'd0, rnd64());
    push_item(rprq_pkg::FUNC_RESERVE, 8'hff, rnd64());
    push_item(rprq_pkg::FUNC_PEEK, 8'd0, rnd64());
    push_item(rprq_pkg::FUNC_POP, 8'd0, rnd64());
    push_item(rprq_pkg::FUNC_PUBLISH, 8'd1, rnd64());
    push_item(rprq_pkg::FUNC_PUBLISH, 8'd0, '1);
    push_item(rprq_pkg::FUNC_PUBLISH, 8'd0, rnd64());
    push_item(rprq_pkg::FUNC_PEEK, 8'd0, '0);
    push_item(rprq_pkg::FUNC_POP, 8'd0, '0);
    push_item(rprq_pkg::FUNC_RESERVE, 8'd0, '0);
    push_item(rprq_pkg::FUNC_RESERVE, 8'd0, '0);
    push_item(rprq_pkg::FUNC_SKIP, 8'd0, rnd64());
    push_item(rprq_pkg::FUNC_SKIP, 8'd0, rnd64());
    push_item(rprq_pkg::FUNC_SKIP, 8'd0, rnd64());
    push_item(3'd5, 8'd0, '0);
    push_item(3'd6, 8'hff, '1);
    push_item(3'd7, 8'h5a, rnd64());
    push_item(rprq_pkg::FUNC_PUBLISH, 8'hff, '1);

    push_cfg(4'd1);
    push_item(rprq_pkg::FUNC_RESERVE, 8'd0, rnd64());
    push_item(rprq_pkg::FUNC_RESERVE, 8'd0, rnd64());
    push_item(rprq_pkg::FUNC_PUBLISH, 8'hff, rnd64());
    push_item(rprq_pkg::FUNC_PUBLISH, 8'd0, '0);
    push_item(rprq_pkg::FUNC_POP, 8'd0, rnd64());

    push_cfg(4'd8);
    add_random(150);
    push_cfg(4'd2);
    add_random(120);
    push_cfg(4'd0);
    add_random(15);
    push_cfg(4'd3);
    add_random(120);
    push_cfg(4'd12);
    add_random(100);
    push_cfg(4'd1);
    add_random(60);
    push_cfg(4'd15);
    add_random(40);
    push_cfg(4'd4);
    add_random(100);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    while (pending_ops.size() != 0 || in_valid || cfg_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
sv/rprq_pkg.sv
sv/rprq_ctrl.sv
sv/rprq_dp.sv
sv/reserve_publish_ring_queue_core.sv
sv/rprq_chk.sv
bench/tb_reserve_publish_ring_queue_core.sv
